FILE: rtl/core/sapo_pkg.sv
// Package for the sparse address to packed offset translator.
// Field widths, register map, operation codes and parameter defaults.
// No dependencies.
`default_nettype none

package sapo_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 8;
  localparam int unsigned ADDR_BITS_DEF    = 32;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned OFFSET_W = 40;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned INDEX_W  = 3;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;

  // register select is paddr bit 3 (registers on 8-byte boundaries)
  localparam logic REG_SEG_COUNT   = 1'b0;
  localparam logic REG_DUMP_OFFSET = 1'b1;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_LOAD      = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/sapo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sapo_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sparse_address_to_packed_offset.sv
// Top level of the sparse address to packed offset translator.
// Depends on sapo_pkg and sapo_ram.
`default_nettype none

// Segment table (start, size) sits in one RAM, one entry per row, written by
// load requests. A translate request walks the table from entry 0, one RAM
// read and one compare/accumulate per cycle, and stops at the first segment
// holding the address or after segment_count entries (capped at MAX_SEGMENTS).
// Its result is registered when the walk ends and moves to the output
// register once that register is free; the next request is taken only after
// that move. Registers: segment_count at byte 0x0, dump_offset at byte 0x8,
// decoded on paddr bit 3.
module sparse_address_to_packed_offset
  import sapo_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,

  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                operation_i,
  input  wire logic [INDEX_W-1:0]  segment_index_i,
  input  wire logic [FIELD_W-1:0]  segment_start_i,
  input  wire logic [FIELD_W-1:0]  segment_size_i,
  input  wire logic [FIELD_W-1:0]  physical_address_i,

  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [OFFSET_W-1:0] packed_offset_o,
  output logic                     miss_o
);

  localparam int unsigned AW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [COUNT_W-1:0]  segment_count_q;
  logic [OFFSET_W-1:0] dump_offset_q;
  logic [AW-1:0]       addr_q;
  logic [CW-1:0]       idx_q;
  logic [OFFSET_W-1:0] acc_q;
  logic [OFFSET_W-1:0] res_off_q;
  logic                res_miss_q;
  logic                out_valid_q;
  logic [OFFSET_W-1:0] packed_offset_q;
  logic                miss_q;

  logic                cfg_we;
  logic [CW-1:0]       count_eff;
  logic                in_acc;
  logic                is_load;
  logic                load_ok;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  logic [2*AW-1:0]     ram_rdata;
  logic [AW-1:0]       ent_start;
  logic [AW-1:0]       ent_size;
  logic [AW:0]         ent_end;
  logic                hit;
  logic [CW-1:0]       idx_next;
  logic                last;
  logic                out_free;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3])
      REG_SEG_COUNT:   prdata = APB_DW'(segment_count_q);
      REG_DUMP_OFFSET: prdata = APB_DW'(dump_offset_q);
      default:         prdata = '0;
    endcase
  end

  assign count_eff = (32'(segment_count_q) > 32'(MAX_SEGMENTS)) ?
                     CW'(MAX_SEGMENTS) : CW'(segment_count_q);

  // request side
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_load    = (operation_i == OP_LOAD);
  assign load_ok    = (32'(segment_index_i) < 32'(MAX_SEGMENTS));

  // walk datapath
  assign ent_start = ram_rdata[AW-1:0];
  assign ent_size  = ram_rdata[2*AW-1:AW];
  assign ent_end   = {1'b0, ent_start} + {1'b0, ent_size};
  assign hit       = (ent_start <= addr_q) && ({1'b0, addr_q} < ent_end);
  assign idx_next  = idx_q + CW'(1);
  assign last      = (idx_next == count_eff);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      S_IDLE: begin
        ram_re = in_acc && !is_load && (count_eff != '0);
      end
      S_WALK: begin
        ram_re    = !hit && !last;
        ram_raddr = idx_next[IW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  sapo_ram #(
    .WIDTH (2 * AW),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_load && load_ok),
    .waddr_i (IW'(segment_index_i)),
    .wdata_i ({segment_size_i[AW-1:0], segment_start_i[AW-1:0]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      segment_count_q <= '0;
      dump_offset_q   <= '0;
      out_valid_q     <= 1'b0;
      addr_q          <= '0;
      idx_q           <= '0;
      acc_q           <= '0;
      res_off_q       <= '0;
      res_miss_q      <= 1'b0;
      packed_offset_q <= '0;
      miss_q          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (paddr[3])
          REG_SEG_COUNT:   segment_count_q <= pwdata[COUNT_W-1:0];
          REG_DUMP_OFFSET: dump_offset_q   <= pwdata[OFFSET_W-1:0];
          default:         segment_count_q <= segment_count_q;
        endcase
      end

      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && !is_load) begin
            addr_q <= physical_address_i[AW-1:0];
            idx_q  <= '0;
            acc_q  <= dump_offset_q;
            if (count_eff == '0) begin
              res_off_q  <= '0;
              res_miss_q <= 1'b1;
              state_q    <= S_DONE;
            end else begin
              state_q <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (hit) begin
            res_off_q  <= acc_q + OFFSET_W'(addr_q - ent_start);
            res_miss_q <= 1'b0;
            state_q    <= S_DONE;
          end else if (last) begin
            res_off_q  <= '0;
            res_miss_q <= 1'b1;
            state_q    <= S_DONE;
          end else begin
            acc_q <= acc_q + OFFSET_W'(ent_size);
            idx_q <= idx_next;
          end
        end
        S_DONE: begin
          if (out_free) begin
            packed_offset_q <= res_off_q;
            miss_q          <= res_miss_q;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packed_offset_o = packed_offset_q;
  assign miss_o          = miss_q;

endmodule

`default_nettype wire

FILE: dv/sparse_address_to_packed_offset_test.sv
// Testbench for sparse_address_to_packed_offset: loads segment tables, translates addresses
// and checks every result against a predictor of the segment walk, with random stalls.
// Depends on sapo_pkg and the translator RTL; needs no files or arguments.
`default_nettype none

module sparse_address_to_packed_offset_test;
  import sapo_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_OFF    = 300;
  localparam int unsigned DRAIN       = MAX_SEGMENTS_DEF + 4;

  typedef struct packed {
    logic [FIELD_W-1:0]  address;
    logic [OFFSET_W-1:0] offset;
    logic                miss;
  } offset_result_t;

  class offset_scoreboard;
    logic [FIELD_W-1:0]  seg_start [MAX_SEGMENTS_DEF];
    logic [FIELD_W-1:0]  seg_size  [MAX_SEGMENTS_DEF];
    logic [COUNT_W-1:0]  seg_count   = '0;
    logic [OFFSET_W-1:0] base_offset = '0;
    offset_result_t      expected_q [$];
    int unsigned         errors, hits, misses, loads;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // walk the table in index order, first segment holding the address wins
    function void note_request(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic [FIELD_W-1:0] start, size, addr);
      int unsigned         walk_len;
      logic [OFFSET_W-1:0] walked;
      logic [FIELD_W:0]    seg_end;
      offset_result_t      res;
      if (op == OP_LOAD) begin
        seg_start[idx] = start;
        seg_size[idx]  = size;
        loads++;
        return;
      end
      walk_len    = (seg_count > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : seg_count;
      walked      = '0;
      res.address = addr;
      res.offset  = '0;
      res.miss    = 1'b1;
      for (int i = 0; i < walk_len; i++) begin
        seg_end = {1'b0, seg_start[i]} + {1'b0, seg_size[i]};
        if (addr >= seg_start[i] && {1'b0, addr} < seg_end) begin
          res.offset = base_offset + walked + addr - seg_start[i];
          res.miss   = 1'b0;
          break;
        end
        walked += seg_size[i];
      end
      expected_q.push_back(res);
    endfunction

    task check_result(input logic [OFFSET_W-1:0] offset, input logic miss);
      offset_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request pending: offset %h miss %b", offset, miss));
        return;
      end
      want = expected_q.pop_front();
      if (miss !== want.miss)
        report($sformatf("addr %h: miss %b, want %b", want.address, miss, want.miss));
      if (offset !== want.offset)
        report($sformatf("addr %h: offset %h, want %h", want.address, offset, want.offset));
      if (want.miss) misses++;
      else hits++;
    endtask
  endclass

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                psel               = 1'b0;
  logic                penable            = 1'b0;
  logic                pwrite             = 1'b0;
  logic [APB_AW-1:0]   paddr              = '0;
  logic [APB_DW-1:0]   pwdata             = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i         = 1'b0;
  logic                in_ready_o;
  logic                operation_i        = OP_TRANSLATE;
  logic [INDEX_W-1:0]  segment_index_i    = '0;
  logic [FIELD_W-1:0]  segment_start_i    = '0;
  logic [FIELD_W-1:0]  segment_size_i     = '0;
  logic [FIELD_W-1:0]  physical_address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i        = 1'b0;
  logic [OFFSET_W-1:0] packed_offset_o;
  logic                miss_o;

  offset_scoreboard sb;
  bit               steady_flow  = 1'b0;
  bit               hold_off_req = 1'b0;
  int unsigned      n_settings   = 0;
  int unsigned      quiet_cycles = 0;

  sparse_address_to_packed_offset i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .segment_index_i    (segment_index_i),
    .segment_start_i    (segment_start_i),
    .segment_size_i     (segment_size_i),
    .physical_address_i (physical_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .packed_offset_o    (packed_offset_o),
    .miss_o             (miss_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
                              input logic [FIELD_W-1:0] start, size, addr);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(10, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    operation_i        <= op;
    segment_index_i    <= idx;
    segment_start_i    <= start;
    segment_size_i     <= size;
    physical_address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, idx, start, size, addr);
  endtask

  task automatic load_segment(input logic [INDEX_W-1:0] idx, input logic [FIELD_W-1:0] start,
                              input logic [FIELD_W-1:0] size);
    send_request(OP_LOAD, idx, start, size, $urandom());
  endtask

  task automatic translate(input logic [FIELD_W-1:0] addr);
    send_request(OP_TRANSLATE, INDEX_W'($urandom_range(7, 0)), $urandom(), $urandom(), addr);
  endtask

  // block idle: all results back, then time for a trailing load or walk to finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic program_registers(input logic [COUNT_W-1:0] count,
                                   input logic [OFFSET_W-1:0] offset);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SEG_COUNT, 3'b000};
    pwdata  <= APB_DW'(count);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.seg_count = count;
    penable <= 1'b0;
    paddr   <= {REG_DUMP_OFFSET, 3'b000};
    pwdata  <= APB_DW'(offset);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.base_offset = offset;
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  function automatic void draw_segment(input logic [FIELD_W-1:0] base, input bit allow_huge,
                                       output logic [FIELD_W-1:0] start, size);
    case ($urandom_range(7, 0))
      0: begin
        start = $urandom();
        size  = $urandom();
      end
      1: begin
        start = base + $urandom_range(4096, 0);
        size  = '0;
      end
      2: begin
        start = 32'hFFFF_FFFF - $urandom_range(4096, 0);
        size  = $urandom_range(8192, 1);
      end
      3: begin
        start = allow_huge ? $urandom_range(255, 0) : $urandom();
        size  = allow_huge ? 32'hFFFF_FFFF - $urandom_range(3, 0) : $urandom_range(65535, 0);
      end
      default: begin
        start = base + $urandom_range(4096, 0);
        size  = $urandom_range(2048, 1);
      end
    endcase
  endfunction

  task automatic load_layout();
    logic [FIELD_W-1:0] base, start, size;
    bit                 allow_huge;
    base       = $urandom();
    allow_huge = ($urandom_range(3, 0) == 0);
    for (int k = 0; k < MAX_SEGMENTS_DEF; k++) begin
      draw_segment(base, allow_huge, start, size);
      load_segment(INDEX_W'(k), start, size);
    end
  endtask

  // addresses aimed at segment edges and interiors, some fully random
  function automatic logic [FIELD_W-1:0] pick_address();
    int unsigned        k;
    logic [FIELD_W-1:0] s, z;
    k = $urandom_range(MAX_SEGMENTS_DEF - 1, 0);
    s = sb.seg_start[k];
    z = sb.seg_size[k];
    case ($urandom_range(7, 0))
      0, 1:    return $urandom();
      2:       return s;
      3:       return s + z - 1;
      4:       return s + z;
      5:       return s - 1;
      default: return s + ((z == 0) ? 32'd0 : $urandom() % z);
    endcase
  endfunction

  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end
      gap = steady_flow ? 0 : $urandom_range(10, 0);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(packed_offset_o, miss_o);
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0]  s, z;
    logic [COUNT_W-1:0]  cnt;
    logic [OFFSET_W-1:0] offs;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // count 0 after reset: always a miss
    translate(32'h0000_0000);
    translate(32'hFFFF_FFFF);
    // overlap, empty segment, end past the top of the address space, full-range segment
    load_segment(3'd0, 32'h0000_1000, 32'h0000_0100);
    load_segment(3'd1, 32'h0000_1080, 32'h0000_0100);
    load_segment(3'd2, 32'h0000_5000, 32'h0000_0000);
    load_segment(3'd3, 32'hFFFF_FF00, 32'h0000_0200);
    load_segment(3'd4, 32'h0000_0000, 32'hFFFF_FFFF);
    load_segment(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_segment(3'd6, 32'h8000_0000, 32'h0000_0001);
    load_segment(3'd7, 32'h1234_5678, 32'h0000_0010);
    settle_block();
    program_registers(COUNT_W'(8), 40'h12_3456_789A);
    translate(32'h0000_1000);
    translate(32'h0000_10FF);
    translate(32'h0000_1100);
    translate(32'h0000_1180);
    translate(32'h0000_5000);
    translate(32'hFFFF_FF00);
    translate(32'hFFFF_FFFF);
    translate(32'h8000_0000);
    settle_block();
    program_registers(COUNT_W'(3), 40'h0);
    translate(32'h0000_5000);
    translate(32'h0000_117F);

    for (int p = 0; p < 10; p++) begin
      settle_block();
      case (p)
        0:       cnt = COUNT_W'(8);
        1:       cnt = COUNT_W'(15);
        2:       cnt = COUNT_W'(0);
        3:       cnt = COUNT_W'(1);
        default: cnt = COUNT_W'($urandom_range(15, 0));
      endcase
      case (p)
        0:       offs = '0;
        1:       offs = {OFFSET_W{1'b1}};
        6:       offs = {OFFSET_W{1'b1}} - $urandom_range(65535, 0);
        default: offs = {8'($urandom_range(255, 0)), 32'($urandom())};
      endcase
      program_registers(cnt, offs);
      steady_flow = (p == 4 || p == 7);
      if (p == 5) hold_off_req = 1'b1;
      load_layout();
      repeat (190) begin
        if ($urandom_range(99, 0) < 12) begin
          draw_segment($urandom(), 1'b0, s, z);
          load_segment(INDEX_W'($urandom_range(7, 0)), s, z);
        end else begin
          translate(pick_address());
        end
      end
    end

    settle_block();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d translate requests never answered", sb.pending()));
    $display("run: %0d translations checked (%0d hits, %0d misses), %0d segment loads",
             sb.hits + sb.misses, sb.hits, sb.misses, sb.loads);
    $display("run: %0d register settings incl. counts 0, 1, 8, 15 and offset wrap",
             n_settings);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
